// File: hw/rtl/quaternion_rotation_matrix_jacobian_macros.svh
// ----------------------------------------------------------------------------
// quaternion_rotation_matrix_jacobian_macros.svh
// Assertion shorthands shared by the quaternion rotation matrix design.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ROTATION_MATRIX_JACOBIAN_MACROS_SVH
`define QUATERNION_ROTATION_MATRIX_JACOBIAN_MACROS_SVH

// same-cycle implication, clocked by clk, off during rst
`define QRMJ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked by clk, off during rst
`define QRMJ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/qrmj_pkg.sv
// ----------------------------------------------------------------------------
// qrmj_pkg
// Widths, coefficient tables and types of the quaternion rotation matrix block.
// ----------------------------------------------------------------------------
package qrmj_pkg;

  // field and datapath widths
  localparam int QW   = 16;  // quaternion component, Q2.14
  localparam int PW   = 32;  // component product
  localparam int BW   = 33;  // matrix numerator term, signed
  localparam int NW   = 33;  // squared norm, unsigned
  localparam int DW   = 65;  // divisor, up to the norm squared
  localparam int P1W  = 50;  // component times norm
  localparam int P2W  = 49;  // term times component
  localparam int NUMW = 52;  // signed dividend
  localparam int MAGW = 51;  // dividend magnitude
  localparam int QB   = 33;  // quotient bits, one of them the rounding bit
  localparam int VW   = 32;  // Q16.16 result

  // fraction shifts of the two kinds of element
  localparam int ROT_SH = 16;
  localparam int DER_SH = 30;

  // matrix and row codes
  localparam logic [2:0] MAT_ROT      = 3'd0;
  localparam logic [2:0] MAT_LAST_DER = 3'd4;
  localparam logic [1:0] ROW_FIRST    = 2'd0;
  localparam logic [1:0] ROW_LAST     = 2'd2;

  // register index taken from paddr[2]
  localparam logic REG_EMIT_DERIV = 1'b0;

  // saturation limits of the magnitude
  localparam logic [QB-1:0] LIM_POS = 33'h0_7FFF_FFFF;
  localparam logic [QB-1:0] LIM_NEG = 33'h0_8000_0000;

  // rotation and derivative coefficients, row-major
  localparam logic signed [3:0] ROT_COEF [9] = '{
    4'sd1, 4'sd2, 4'sd2, 4'sd2, -4'sd1, 4'sd2, 4'sd2, -4'sd2, -4'sd1
  };
  localparam logic signed [3:0] DER_COEF [9] = '{
    -4'sd2, -4'sd4, -4'sd4, -4'sd4, 4'sd2, -4'sd4, -4'sd4, 4'sd4, 4'sd2
  };
  // signed component of the linear term: 1=x 2=y 3=z 4=w, minus for negative
  localparam logic signed [3:0] LIN_SEL [4][9] = '{
    '{ 4'sd1,  4'sd2,  4'sd3,  4'sd2, -4'sd1,  4'sd4,  4'sd3, -4'sd4, -4'sd1},
    '{-4'sd2,  4'sd1, -4'sd4,  4'sd1,  4'sd2,  4'sd3,  4'sd4,  4'sd3, -4'sd2},
    '{-4'sd3,  4'sd4,  4'sd1, -4'sd4, -4'sd3,  4'sd2,  4'sd1,  4'sd2,  4'sd3},
    '{ 4'sd4,  4'sd3, -4'sd2, -4'sd3,  4'sd4,  4'sd1,  4'sd2, -4'sd1,  4'sd4}
  };

  typedef logic signed [QW-1:0] comp_t;
  typedef logic signed [BW-1:0] bval_t;

  // per-quaternion values held while its rows go out
  typedef struct packed {
    comp_t [3:0]   q;
    bval_t [8:0]   b;
    logic [NW-1:0] n;
    logic [DW-1:0] nsq;
    logic          degen;
  } item_t;

  typedef struct packed {
    logic [2:0] mat;
    logic [1:0] row;
    logic       last;
    logic       degen;
  } meta_t;

  typedef struct packed {
    logic            neg;
    logic [MAGW-1:0] hi;
    logic [QB-1:0]   lo;
  } lane_t;

  typedef struct packed {
    meta_t         meta;
    logic [DW-1:0] den;
    lane_t [2:0]   lane;
  } row_t;

  typedef struct packed {
    meta_t             meta;
    logic [2:0][VW-1:0] val;
  } res_t;

  // signed 16x16 product
  function automatic logic signed [PW-1:0] mul_qq(input comp_t a, input comp_t b);
    logic signed [PW-1:0] ea;
    logic signed [PW-1:0] eb;
    ea = PW'(a);
    eb = PW'(b);
    return ea * eb;
  endfunction

  // square of the norm
  function automatic logic [DW-1:0] mul_nn(input logic [NW-1:0] a);
    logic [DW-1:0] ea;
    ea = DW'(a);
    return ea * ea;
  endfunction

endpackage

// File: hw/rtl/qrmj_in_if.sv
// ----------------------------------------------------------------------------
// qrmj_in_if
// Quaternion input channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qrmj_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   quat_x;
  logic signed [15:0]   quat_y;
  logic signed [15:0]   quat_z;
  logic signed [15:0]   quat_w;

  modport source (output valid, output quat_x, output quat_y, output quat_z,
                  output quat_w, input ready);
  modport sink (input valid, input quat_x, input quat_y, input quat_z,
                input quat_w, output ready);
endinterface

// File: hw/rtl/qrmj_out_if.sv
// ----------------------------------------------------------------------------
// qrmj_out_if
// Matrix row output channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qrmj_out_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           matrix_sel;
  logic [1:0]           row_index;
  logic signed [31:0]   value_c0;
  logic signed [31:0]   value_c1;
  logic signed [31:0]   value_c2;
  logic                 degenerate;
  logic                 last_row;

  modport source (output valid, output matrix_sel, output row_index,
                  output value_c0, output value_c1, output value_c2,
                  output degenerate, output last_row, input ready);
  modport sink (input valid, input matrix_sel, input row_index,
                input value_c0, input value_c1, input value_c2,
                input degenerate, input last_row, output ready);
endinterface

// File: hw/rtl/qrmj_front.sv
// ----------------------------------------------------------------------------
// qrmj_front
// Four-stage front end: input register, products, norm and terms, norm squared.
// ----------------------------------------------------------------------------
module qrmj_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  qrmj_pkg::comp_t [3:0]    in_q,
  output qrmj_pkg::item_t          item,
  output logic                     item_valid,
  input  logic                     take
);

  logic [3:0]                        v;
  logic [3:0]                        en;
  qrmj_pkg::comp_t [3:0]             q0;
  qrmj_pkg::comp_t [3:0]             q1;
  qrmj_pkg::comp_t [3:0]             q2;
  qrmj_pkg::comp_t [3:0]             q3;
  logic [3:0][qrmj_pkg::PW-1:0]      sq1;
  logic [5:0][qrmj_pkg::PW-1:0]      cr1;
  qrmj_pkg::bval_t                   t [4];
  qrmj_pkg::bval_t                   c [6];
  logic [qrmj_pkg::NW-1:0]           n2;
  logic [qrmj_pkg::NW-1:0]           n3;
  qrmj_pkg::bval_t [8:0]             b2;
  qrmj_pkg::bval_t [8:0]             b3;
  logic [qrmj_pkg::DW-1:0]           nsq3;

  // a stage moves when it is empty or its successor moves
  assign en[3]    = !v[3] || take;
  assign en[2]    = !v[2] || en[3];
  assign en[1]    = !v[1] || en[2];
  assign en[0]    = !v[0] || en[1];
  assign in_ready = en[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
  end

  // sign-extended squares and cross products
  always_comb begin
    for (int i = 0; i < 4; i++) t[i] = qrmj_pkg::BW'($signed(sq1[i]));
    for (int i = 0; i < 6; i++) c[i] = qrmj_pkg::BW'($signed(cr1[i]));
  end

  // data stages
  always_ff @(posedge clk) begin
    if (en[0]) q0 <= in_q;
    if (en[1]) begin
      q1 <= q0;
      for (int i = 0; i < 4; i++) sq1[i] <= qrmj_pkg::mul_qq(q0[i], q0[i]);
      cr1[0] <= qrmj_pkg::mul_qq(q0[0], q0[1]);  // xy
      cr1[1] <= qrmj_pkg::mul_qq(q0[3], q0[2]);  // wz
      cr1[2] <= qrmj_pkg::mul_qq(q0[0], q0[2]);  // xz
      cr1[3] <= qrmj_pkg::mul_qq(q0[3], q0[1]);  // wy
      cr1[4] <= qrmj_pkg::mul_qq(q0[3], q0[0]);  // wx
      cr1[5] <= qrmj_pkg::mul_qq(q0[1], q0[2]);  // yz
    end
    if (en[2]) begin
      q2    <= q1;
      n2    <= qrmj_pkg::NW'(sq1[0]) + qrmj_pkg::NW'(sq1[1])
             + qrmj_pkg::NW'(sq1[2]) + qrmj_pkg::NW'(sq1[3]);
      b2[0] <= t[0] - t[1] - t[2] + t[3];
      b2[1] <= c[0] + c[1];
      b2[2] <= c[2] - c[3];
      b2[3] <= c[0] - c[1];
      b2[4] <= t[0] - t[1] + t[2] - t[3];
      b2[5] <= c[4] + c[5];
      b2[6] <= c[3] + c[2];
      b2[7] <= c[4] - c[5];
      b2[8] <= t[0] + t[1] - t[2] - t[3];
    end
    if (en[3]) begin
      q3   <= q2;
      n3   <= n2;
      b3   <= b2;
      nsq3 <= qrmj_pkg::mul_nn(n2);
    end
  end

  assign item.q     = q3;
  assign item.b     = b3;
  assign item.n     = n3;
  assign item.nsq   = nsq3;
  assign item.degen = (n3 == '0);
  assign item_valid = v[3];

endmodule

// File: hw/rtl/qrmj_rowgen.sv
// ----------------------------------------------------------------------------
// qrmj_rowgen
// Row sequencer and dividend stages: multiply, sum, magnitude and alignment.
// ----------------------------------------------------------------------------
`include "quaternion_rotation_matrix_jacobian_macros.svh"

module qrmj_rowgen (
  input  logic              clk,
  input  logic              rst,
  input  qrmj_pkg::item_t   item,
  input  logic              item_valid,
  output logic              take,
  input  logic              emit,
  input  logic              adv,
  output qrmj_pkg::row_t    row_o,
  output logic              row_valid
);

  qrmj_pkg::item_t              hold;
  logic                         busy;
  logic                         deriv;
  logic [2:0]                   mat;
  logic [1:0]                   row;
  logic                         is_last;
  logic                         rot;
  logic [1:0]                   dm;

  logic [3:0]                   e [3];
  logic signed [3:0]            sel [3];
  logic signed [3:0]            sel_mag [3];
  logic [1:0]                   cidx [3];
  qrmj_pkg::comp_t              cq [3];
  qrmj_pkg::comp_t              ma;
  qrmj_pkg::bval_t              bv [3];
  logic signed [qrmj_pkg::P1W-1:0] p1 [3];
  logic signed [qrmj_pkg::P2W-1:0] p2 [3];
  logic signed [2:0]            c1 [3];
  logic signed [3:0]            c2 [3];

  // multiply stage
  logic                         m_v;
  qrmj_pkg::meta_t              m_meta;
  logic [qrmj_pkg::DW-1:0]      m_den;
  logic                         m_rot;
  logic signed [qrmj_pkg::P1W-1:0] m_p1 [3];
  logic signed [qrmj_pkg::P2W-1:0] m_p2 [3];
  logic signed [2:0]            m_c1 [3];
  logic signed [3:0]            m_c2 [3];

  // sum stage
  logic                         a_v;
  qrmj_pkg::meta_t              a_meta;
  logic [qrmj_pkg::DW-1:0]      a_den;
  logic                         a_rot;
  logic signed [qrmj_pkg::NUMW-1:0] a_num [3];

  // magnitude stage
  logic [qrmj_pkg::MAGW-1:0]    mag [3];
  logic [qrmj_pkg::MAGW+qrmj_pkg::QB-1:0] nfull [3];
  logic                         b_v;
  qrmj_pkg::row_t               b_row;

  // last row of the current quaternion
  assign rot     = (mat == qrmj_pkg::MAT_ROT);
  assign is_last = (row == qrmj_pkg::ROW_LAST)
                && (deriv ? (mat == qrmj_pkg::MAT_LAST_DER) : rot);
  assign take    = !busy || (adv && is_last);

  // row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      deriv <= 1'b1;
      mat   <= qrmj_pkg::MAT_ROT;
      row   <= qrmj_pkg::ROW_FIRST;
    end else if (take && item_valid) begin
      busy  <= 1'b1;
      deriv <= emit;
      mat   <= qrmj_pkg::MAT_ROT;
      row   <= qrmj_pkg::ROW_FIRST;
    end else if (busy && adv) begin
      if (is_last) begin
        busy <= 1'b0;
      end else if (row == qrmj_pkg::ROW_LAST) begin
        row <= qrmj_pkg::ROW_FIRST;
        mat <= mat + 3'd1;
      end else begin
        row <= row + 2'd1;
      end
    end
  end

  // quaternion being expanded
  always_ff @(posedge clk) begin
    if (take && item_valid) hold <= item;
  end

  // operand selection for the three columns of this row
  always_comb begin
    dm = 2'(mat - 3'd1);
    ma = rot ? qrmj_pkg::comp_t'(1) : hold.q[dm];
    for (int k = 0; k < 3; k++) begin
      e[k]       = {2'b00, row} * 4'd3 + 4'(k);
      sel[k]     = qrmj_pkg::LIN_SEL[dm][e[k]];
      sel_mag[k] = sel[k][3] ? -sel[k] : sel[k];
      cidx[k]    = 2'(sel_mag[k] - 4'sd1);
      cq[k]      = hold.q[cidx[k]];
      bv[k]      = hold.b[e[k]];
      p1[k]      = rot ? '0
                 : qrmj_pkg::P1W'(cq[k]) * qrmj_pkg::P1W'($signed({1'b0, hold.n}));
      p2[k]      = qrmj_pkg::P2W'(bv[k]) * qrmj_pkg::P2W'(ma);
      c1[k]      = rot ? 3'sd0 : (sel[k][3] ? -3'sd2 : 3'sd2);
      c2[k]      = rot ? qrmj_pkg::ROT_COEF[e[k]] : qrmj_pkg::DER_COEF[e[k]];
    end
  end

  // magnitude and alignment of the dividend
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]   = qrmj_pkg::MAGW'(a_num[k][qrmj_pkg::NUMW-1] ? -a_num[k] : a_num[k]);
      nfull[k] = a_rot
               ? (qrmj_pkg::MAGW+qrmj_pkg::QB)'(mag[k]) << (qrmj_pkg::ROT_SH + 1)
               : (qrmj_pkg::MAGW+qrmj_pkg::QB)'(mag[k]) << (qrmj_pkg::DER_SH + 1);
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else if (adv) begin
      m_v <= busy;
      a_v <= m_v;
      b_v <= a_v;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      m_meta.mat   <= mat;
      m_meta.row   <= row;
      m_meta.last  <= is_last;
      m_meta.degen <= hold.degen;
      m_den        <= rot ? qrmj_pkg::DW'(hold.n) : hold.nsq;
      m_rot        <= rot;
      for (int k = 0; k < 3; k++) begin
        m_p1[k] <= p1[k];
        m_p2[k] <= p2[k];
        m_c1[k] <= c1[k];
        m_c2[k] <= c2[k];
      end
      a_meta <= m_meta;
      a_den  <= m_den;
      a_rot  <= m_rot;
      for (int k = 0; k < 3; k++) begin
        a_num[k] <= qrmj_pkg::NUMW'(m_p1[k]) * qrmj_pkg::NUMW'(m_c1[k])
                  + qrmj_pkg::NUMW'(m_p2[k]) * qrmj_pkg::NUMW'(m_c2[k]);
      end
      b_row.meta <= a_meta;
      b_row.den  <= a_den;
      for (int k = 0; k < 3; k++) begin
        b_row.lane[k].neg <= a_num[k][qrmj_pkg::NUMW-1];
        b_row.lane[k].hi  <= nfull[k][qrmj_pkg::MAGW+qrmj_pkg::QB-1:qrmj_pkg::QB];
        b_row.lane[k].lo  <= nfull[k][qrmj_pkg::QB-1:0];
      end
    end
  end

  assign row_o     = b_row;
  assign row_valid = b_v;

  `QRMJ_ASSERT_IMPL(a_mat_range, busy, (mat <= qrmj_pkg::MAT_LAST_DER) && (deriv || rot), "row counter beyond last matrix")
  `QRMJ_ASSERT_NEXT(a_stay_busy, busy && adv && !is_last, busy, "sequencer dropped rows of a quaternion")

endmodule

// File: hw/rtl/qrmj_divider.sv
// ----------------------------------------------------------------------------
// qrmj_divider
// Three-lane pipelined restoring divider, one quotient bit per stage, with
// rounding, saturation and the zero-norm override in the final stage.
// ----------------------------------------------------------------------------
module qrmj_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  qrmj_pkg::row_t    row_i,
  input  logic              row_valid,
  output qrmj_pkg::res_t    res,
  output logic              res_valid
);

  localparam int QB = qrmj_pkg::QB;
  localparam int DW = qrmj_pkg::DW;

  logic [QB:0]           sv;
  logic                  fv;
  qrmj_pkg::meta_t       smeta [QB+1];
  logic [DW-1:0]         sden  [QB+1];
  logic [DW-1:0]         srem  [QB+1][3];
  logic [QB-1:0]         sw    [QB+1][3];
  logic                  sneg  [QB+1][3];
  logic                  ssat  [QB+1][3];

  logic                  sat0 [3];
  logic [QB-1:0]         rnd  [3];
  logic [QB-1:0]         lim  [3];
  logic [QB-1:0]         fmag [3];
  logic [qrmj_pkg::VW-1:0] fval [3];
  qrmj_pkg::res_t        fres;

  // valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
      fv <= 1'b0;
    end else if (adv) begin
      sv <= {sv[QB-1:0], row_valid};
      fv <= sv[QB];
    end
  end

  // overflow check: quotient would need more than QB bits
  always_comb begin
    for (int k = 0; k < 3; k++) sat0[k] = DW'(row_i.lane[k].hi) >= row_i.den;
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (adv) begin
      smeta[0] <= row_i.meta;
      sden[0]  <= row_i.den;
      for (int k = 0; k < 3; k++) begin
        srem[0][k] <= sat0[k] ? '0 : DW'(row_i.lane[k].hi);
        sw[0][k]   <= row_i.lane[k].lo;
        sneg[0][k] <= row_i.lane[k].neg;
        ssat[0][k] <= sat0[k];
      end
    end
  end

  // one quotient bit per stage
  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [DW:0] r2   [3];
    logic [DW:0] diff [3];
    logic        ge   [3];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        r2[k]   = {srem[s-1][k], sw[s-1][k][QB-1]};
        diff[k] = r2[k] - {1'b0, sden[s-1]};
        ge[k]   = r2[k] >= {1'b0, sden[s-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        smeta[s] <= smeta[s-1];
        sden[s]  <= sden[s-1];
        for (int k = 0; k < 3; k++) begin
          srem[s][k] <= ge[k] ? diff[k][DW-1:0] : r2[k][DW-1:0];
          sw[s][k]   <= {sw[s-1][k][QB-2:0], ge[k]};
          sneg[s][k] <= sneg[s-1][k];
          ssat[s][k] <= ssat[s-1][k];
        end
      end
    end
  end

  // round half away from zero, saturate, apply sign
  always_comb begin
    fres.meta = smeta[QB];
    for (int k = 0; k < 3; k++) begin
      rnd[k]  = {1'b0, sw[QB][k][QB-1:1]} + QB'(sw[QB][k][0]);
      lim[k]  = sneg[QB][k] ? qrmj_pkg::LIM_NEG : qrmj_pkg::LIM_POS;
      fmag[k] = (ssat[QB][k] || (rnd[k] > lim[k])) ? lim[k] : rnd[k];
      fval[k] = smeta[QB].degen ? '0
              : (sneg[QB][k] ? qrmj_pkg::VW'(-fmag[k]) : qrmj_pkg::VW'(fmag[k]));
      fres.val[k] = fval[k];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) res <= fres;
  end

  assign res_valid = fv;

endmodule

// File: hw/rtl/quaternion_rotation_matrix_jacobian.sv
// After an input transfer its rows follow one row a cycle while result.ready keeps
// the row pipeline moving. A new quaternion enters the row sequencer only as the last row of the previous one
// is issued, set by the single row path into the 33-stage divider that yields one row per cycle when not stalled.
// Reset (rst, synchronous): all valid bits and the row sequencer clear,
// emit_derivatives returns to 1.
// ----------------------------------------------------------------------------
// quaternion_rotation_matrix_jacobian
// Rotation matrix of an unnormalized quaternion and its four partial
// derivative matrices (when emit_derivatives is 1), one row per output transfer, Q16.16 saturated.
// ----------------------------------------------------------------------------
`include "quaternion_rotation_matrix_jacobian_macros.svh"

module quaternion_rotation_matrix_jacobian (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  qrmj_in_if.sink      quat,
  qrmj_out_if.source   result
);

  logic                    emit_deriv;
  logic                    adv;
  qrmj_pkg::comp_t [3:0]   in_q;
  qrmj_pkg::item_t         item;
  logic                    item_valid;
  logic                    take;
  qrmj_pkg::row_t          row_d;
  logic                    row_valid;
  qrmj_pkg::res_t          res;
  logic                    res_valid;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_deriv <= 1'b1;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == qrmj_pkg::REG_EMIT_DERIV)) begin
      emit_deriv <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == qrmj_pkg::REG_EMIT_DERIV) ? {31'b0, emit_deriv} : '0;

  // row pipeline moves when the output register is free or being taken
  assign adv = !res_valid || result.ready;

  assign in_q[0] = quat.quat_x;
  assign in_q[1] = quat.quat_y;
  assign in_q[2] = quat.quat_z;
  assign in_q[3] = quat.quat_w;

  qrmj_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (quat.valid),
    .in_ready   (quat.ready),
    .in_q       (in_q),
    .item       (item),
    .item_valid (item_valid),
    .take       (take)
  );

  qrmj_rowgen u_rowgen (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .take       (take),
    .emit       (emit_deriv),
    .adv        (adv),
    .row_o      (row_d),
    .row_valid  (row_valid)
  );

  qrmj_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .row_i      (row_d),
    .row_valid  (row_valid),
    .res        (res),
    .res_valid  (res_valid)
  );

  // result transfer
  assign result.valid      = res_valid;
  assign result.matrix_sel = res.meta.mat;
  assign result.row_index  = res.meta.row;
  assign result.value_c0   = res.val[0];
  assign result.value_c1   = res.val[1];
  assign result.value_c2   = res.val[2];
  assign result.degenerate = res.meta.degen;
  assign result.last_row   = res.meta.last;

  `QRMJ_ASSERT_IMPL(a_degen_zero, result.valid && result.degenerate, (result.value_c0 == 0) && (result.value_c1 == 0) && (result.value_c2 == 0), "zero quaternion row carries nonzero values")
  `QRMJ_ASSERT_IMPL(a_last_row, result.valid && result.last_row, (result.row_index == qrmj_pkg::ROW_LAST) && ((result.matrix_sel == qrmj_pkg::MAT_ROT) || (result.matrix_sel == qrmj_pkg::MAT_LAST_DER)), "final row marked on wrong row")

endmodule

// File: test/tb_quaternion_rotation_matrix_jacobian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_rotation_matrix_jacobian
// Self-checking bench for the quaternion rotation matrix block: quaternions go
// in over a valid/ready channel and every matrix row that comes back is
// checked against an exact rational predictor, with emit_derivatives switched
// between phases over the register port and random idling on both sides.
// ----------------------------------------------------------------------------
module tb_quaternion_rotation_matrix_jacobian;

  // one expected matrix row
  typedef struct {
    logic [2:0]  sel;
    logic [1:0]  row;
    logic [31:0] c [3];
    logic        degen;
    logic        last;
  } row_exp_t;

  // directed stimulus, optional typed first rotation row
  typedef struct {
    qrmj_pkg::comp_t x, y, z, w;
    bit              typed;
    logic [31:0]     r0 [3];
  } vec_t;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  qrmj_in_if  quat_if ();
  qrmj_out_if res_if ();

  quaternion_rotation_matrix_jacobian u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quat    (quat_if),
    .result  (res_if)
  );

  row_exp_t   rows_q [$];
  bit         emit_deriv;
  int         err_cnt;
  int         rows_done;
  int         quats_sent;
  int         degen_seen;
  int         long_hold;
  int         out_gap;
  bit         calm;

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // round num * 2^sh / den to nearest, ties away from zero, then saturate
  function automatic logic [31:0] to_q16(longint num, int sh, logic [127:0] den);
    logic [127:0] mag, quo, rem;
    logic         neg;
    neg = num < 0;
    mag = neg ? 128'(-num) : 128'(num);
    mag = mag << sh;
    quo = mag / den;
    rem = mag % den;
    if ((rem << 1) >= den) quo = quo + 1;
    if (neg) begin
      if (quo > 128'h8000_0000) quo = 128'h8000_0000;
      return 32'(-quo);
    end
    if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
    return quo[31:0];
  endfunction

  // expected rows of one quaternion, appended to the row queue
  function automatic void predict_rows(qrmj_pkg::comp_t x, qrmj_pkg::comp_t y,
                                       qrmj_pkg::comp_t z, qrmj_pkg::comp_t w);
    longint       q [4];
    longint       b [9];
    longint       n, t1, t2, t3, t4, comp, lin, num;
    logic [127:0] d1, d2;
    int           nmat, total, k, sel, e;
    row_exp_t     r;
    q[0] = x; q[1] = y; q[2] = z; q[3] = w;
    t1 = q[0] * q[0]; t2 = q[1] * q[1]; t3 = q[2] * q[2]; t4 = q[3] * q[3];
    n = t1 + t2 + t3 + t4;
    b[0] = t1 - t2 - t3 + t4;      b[1] = q[0] * q[1] + q[3] * q[2];
    b[2] = q[0] * q[2] - q[3] * q[1]; b[3] = q[0] * q[1] - q[3] * q[2];
    b[4] = t1 - t2 + t3 - t4;      b[5] = q[3] * q[0] + q[1] * q[2];
    b[6] = q[3] * q[1] + q[0] * q[2]; b[7] = q[3] * q[0] - q[1] * q[2];
    b[8] = t1 + t2 - t3 - t4;
    d1 = 128'(n);
    d2 = d1 * d1;
    nmat = emit_deriv ? 5 : 1;
    total = nmat * 3;
    k = 0;
    for (int m = 0; m < nmat; m++) begin
      for (int rw = 0; rw < 3; rw++) begin
        r.sel = 3'(m);
        r.row = 2'(rw);
        for (int c = 0; c < 3; c++) begin
          e = rw * 3 + c;
          r.c[c] = '0;
          if (n != 0) begin
            if (m == 0) begin
              r.c[c] = to_q16(longint'(qrmj_pkg::ROT_COEF[e]) * b[e],
                              qrmj_pkg::ROT_SH, d1);
            end else begin
              sel = qrmj_pkg::LIN_SEL[m-1][e];
              comp = q[(sel < 0 ? -sel : sel) - 1];
              lin = sel < 0 ? -2 * comp : 2 * comp;
              num = lin * n + longint'(qrmj_pkg::DER_COEF[e]) * b[e] * q[m-1];
              r.c[c] = to_q16(num, qrmj_pkg::DER_SH, d2);
            end
          end
        end
        r.degen = (n == 0);
        r.last = (k == total - 1);
        rows_q.push_back(r);
        k++;
      end
    end
  endfunction

  // quaternion sender: random gap, then hold valid until the transfer
  task automatic send_quat(qrmj_pkg::comp_t x, qrmj_pkg::comp_t y,
                           qrmj_pkg::comp_t z, qrmj_pkg::comp_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      quat_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    quat_if.valid  <= 1'b1;
    quat_if.quat_x <= x;
    quat_if.quat_y <= y;
    quat_if.quat_z <= z;
    quat_if.quat_w <= w;
    do @(posedge clk); while (!quat_if.ready);
    predict_rows(x, y, z, w);
    quats_sent++;
  endtask

  // let every expected row arrive, then let the pipe settle
  task automatic drain();
    quat_if.valid <= 1'b0;
    while (rows_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // register write, setup then access
  task automatic write_emit(bit val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {qrmj_pkg::REG_EMIT_DERIV, 2'b00};
    pwdata  <= {31'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    emit_deriv = val;
  endtask

  // random quaternion, mostly full range with some small and sparse ones
  task automatic send_random();
    qrmj_pkg::comp_t v [4];
    int              mode, pick;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      if (mode <= 5) v[i] = qrmj_pkg::comp_t'($urandom());
      else if (mode <= 7) v[i] = qrmj_pkg::comp_t'($urandom_range(0, 128)) - 16'sd64;
      else v[i] = '0;
    end
    if (mode == 8) begin
      pick = $urandom_range(0, 3);
      v[pick] = qrmj_pkg::comp_t'($urandom());
    end else if (mode == 9 && $urandom_range(0, 1)) begin
      pick = $urandom_range(0, 3);
      v[pick] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    end
    send_quat(v[0], v[1], v[2], v[3]);
  endtask

  // row receiver: per-transfer stall, one long hold, quiet stretches
  always @(posedge clk) begin
    int g;
    if (rst) begin
      res_if.ready <= 1'b0;
      out_gap      <= 0;
      long_hold    <= 0;
    end else if (long_hold > 0) begin
      long_hold    <= long_hold - 1;
      res_if.ready <= 1'b0;
    end else if (res_if.valid && res_if.ready) begin
      if (rows_done == 1000) begin
        long_hold    <= 400;
        res_if.ready <= 1'b0;
      end else if (calm) begin
        res_if.ready <= 1'b1;
      end else begin
        g = $urandom_range(0, 3);
        if (g == 0) begin
          res_if.ready <= 1'b1;
        end else begin
          out_gap      <= g - 1;
          res_if.ready <= 1'b0;
        end
      end
    end else if (out_gap > 0) begin
      out_gap      <= out_gap - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // row checker
  always @(posedge clk) begin
    row_exp_t ex;
    if (!rst && res_if.valid && res_if.ready) begin
      rows_done++;
      if (rows_done % 300 == 0) calm = !calm;
      if (rows_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected row: sel %0d row %0d",
                                    res_if.matrix_sel, res_if.row_index);
      end else begin
        ex = rows_q.pop_front();
        if (ex.degen) degen_seen++;
        if (res_if.matrix_sel !== ex.sel || res_if.row_index !== ex.row ||
            res_if.value_c0 !== ex.c[0] || res_if.value_c1 !== ex.c[1] ||
            res_if.value_c2 !== ex.c[2] || res_if.degenerate !== ex.degen ||
            res_if.last_row !== ex.last) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("row mismatch exp: sel %0d row %0d %h %h %h degen %b last %b",
                     ex.sel, ex.row, ex.c[0], ex.c[1], ex.c[2], ex.degen, ex.last);
            $display("             got: sel %0d row %0d %h %h %h degen %b last %b",
                     res_if.matrix_sel, res_if.row_index, res_if.value_c0,
                     res_if.value_c1, res_if.value_c2, res_if.degenerate,
                     res_if.last_row);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    #6ms;
    $display("quaternion_rotation_matrix_jacobian test failed");
    $finish;
  end

  // main sequence
  initial begin
    vec_t  dir [$];
    vec_t  v;
    int    base;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    quat_if.valid = 1'b0;
    quat_if.quat_x = '0; quat_if.quat_y = '0; quat_if.quat_z = '0; quat_if.quat_w = '0;
    emit_deriv = 1'b1;
    err_cnt = 0; rows_done = 0; quats_sent = 0; degen_seen = 0;
    calm = 1'b0;

    // directed rows: zero, axis unit values, extremes, tiny components
    dir.push_back('{x: 0, y: 0, z: 0, w: 0, typed: 1, r0: '{0, 0, 0}});
    dir.push_back('{x: 0, y: 0, z: 0, w: 16384, typed: 1, r0: '{65536, 0, 0}});
    dir.push_back('{x: 16384, y: 0, z: 0, w: 0, typed: 1, r0: '{65536, 0, 0}});
    dir.push_back('{x: 0, y: 0, z: 0, w: -32768, typed: 1, r0: '{65536, 0, 0}});
    dir.push_back('{x: 0, y: 16384, z: 0, w: 0, typed: 1, r0: '{-65536, 0, 0}});
    dir.push_back('{x: 32767, y: 0, z: 0, w: 0, typed: 0, r0: '{0, 0, 0}});
    dir.push_back('{x: -32768, y: -32768, z: -32768, w: -32768, typed: 0, r0: '{0, 0, 0}});
    dir.push_back('{x: 32767, y: 32767, z: 32767, w: 32767, typed: 0, r0: '{0, 0, 0}});
    dir.push_back('{x: -32768, y: 32767, z: -32768, w: 32767, typed: 0, r0: '{0, 0, 0}});
    dir.push_back('{x: 0, y: 1, z: 0, w: 0, typed: 0, r0: '{0, 0, 0}});
    dir.push_back('{x: 0, y: 0, z: -1, w: 0, typed: 0, r0: '{0, 0, 0}});
    dir.push_back('{x: 1, y: 1, z: 1, w: 1, typed: 0, r0: '{0, 0, 0}});
    dir.push_back('{x: 1, y: -1, z: 0, w: 0, typed: 0, r0: '{0, 0, 0}});
    dir.push_back('{x: 12345, y: -23456, z: 3456, w: -7, typed: 0, r0: '{0, 0, 0}});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, derivatives on from reset
    foreach (dir[i]) begin
      v = dir[i];
      send_quat(v.x, v.y, v.z, v.w);
      if (v.typed) begin
        base = rows_q.size() - (emit_deriv ? 15 : 3);
        rows_q[base].c = v.r0;
      end
    end
    drain();

    // random phases across both register settings
    write_emit(1'b0);
    repeat (100) send_random();
    drain();
    write_emit(1'b1);
    for (int i = 0; i < 140; i++) begin
      // one pause until all rows are back
      if (i == 70) begin
        quat_if.valid <= 1'b0;
        while (rows_q.size() != 0) @(posedge clk);
      end
      send_random();
    end
    drain();
    write_emit(1'b0);
    repeat (80) send_random();
    drain();
    write_emit(1'b1);
    repeat (100) send_random();
    drain();

    $display("sent %0d quaternions, checked %0d rows (%0d degenerate)",
             quats_sent, rows_done, degen_seen);
    $display("emit_derivatives toggled 0/1 across phases, long output hold applied");
    if (err_cnt == 0 && rows_q.size() == 0) begin
      $display("quaternion_rotation_matrix_jacobian test passed");
    end else begin
      $display("quaternion_rotation_matrix_jacobian test failed");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/qrmj_pkg.sv
hw/rtl/qrmj_in_if.sv
hw/rtl/qrmj_out_if.sv
hw/rtl/qrmj_front.sv
hw/rtl/qrmj_rowgen.sv
hw/rtl/qrmj_divider.sv
hw/rtl/quaternion_rotation_matrix_jacobian.sv
test/tb_quaternion_rotation_matrix_jacobian.sv
